@@ sv/tpp_pkg.sv @@
// Shared types and constants for the turtle pen plotter raster block.
package tpp_pkg;

  localparam int GRID_SIZE_DEF = 32;
  localparam int IN_DATA_W     = 8;
  localparam int OUT_DATA_W    = 48;
  localparam int IDX_W         = 5;
  localparam int BITS_W        = 32;
  localparam int DIST_W        = 5;
  localparam int MAX_OUT_ROW   = 31;

  typedef enum logic [2:0] {
    MODE_PEN_UP   = 3'd0,
    MODE_PEN_DOWN = 3'd1,
    MODE_TURN_R   = 3'd2,
    MODE_TURN_L   = 3'd3,
    MODE_MOVE     = 3'd4,
    MODE_PRINT    = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    HEAD_COL_UP   = 2'd0,
    HEAD_ROW_UP   = 2'd1,
    HEAD_COL_DOWN = 2'd2,
    HEAD_ROW_DOWN = 2'd3
  } heading_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAW,
    ST_PRINT
  } state_t;

endpackage

@@ sv/tpp_cell.sv @@
// One bitmap row cell of the rotating row ring.
module tpp_cell
  import tpp_pkg::*;
#(
  parameter int WIDTH = GRID_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift_en,
  input  logic [WIDTH-1:0] d_in,
  output logic [WIDTH-1:0] q
);

  logic [WIDTH-1:0] row_r;
  logic [WIDTH-1:0] row_nxt;

  always_comb begin
    row_nxt = row_r;
    if (shift_en) begin
      row_nxt = d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
    end else begin
      row_r <= row_nxt;
    end
  end

  assign q = row_r;

endmodule

@@ sv/turtle_pen_plotter_raster.sv @@
// Top level of the turtle pen plotter raster block.
//
// Usage:
//   Requests enter on the in_ stream: in_tdata carries a mode and a distance.
//   Pen up/down, turns, pen-up moves and unused modes finish in the accepting
//   cycle. A pen-down move or a print rotates the ring of GRID_SIZE row cells
//   once, one row passing the head cell per cycle unless the output stalls,
//   where the segment mask is ORed in or the row is copied to the output.
//   A print emits rows 0 through the largest drawn row (at most 31) on the
//   out_ stream, one row per shift, tlast on the final row; the first row
//   is loaded into the output register after the state register enters ST_PRINT.
//   The output register is a single stage: while it holds a row the receiver
//   has not taken, the ring stops; no row is lost or repeated.
//   in_tready is high only when no rotation is running, so a new request
//   waits until the rotation, including any output stalls, has finished.
//   Reset (rst_n low, synchronous) clears the bitmap, pen, heading, position
//   and extents, and empties the output register.
module turtle_pen_plotter_raster
  import tpp_pkg::*;
#(
  parameter int GRID_SIZE = GRID_SIZE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [2:0] mode, [7:3] distance
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [4:0] row_index, [36:5] row_bits,
                                            // [41:37] col_extent, [47:42] zero
  output logic                  out_tlast
);

  localparam int RW = (GRID_SIZE > 1) ? $clog2(GRID_SIZE) : 1;
  localparam int CW = ((RW > DIST_W) ? RW : DIST_W) + 1;
  localparam logic [RW-1:0] LAST_K  = RW'(GRID_SIZE - 1);
  localparam logic [CW-1:0] EDGE_HI = CW'(GRID_SIZE - 1);
  localparam logic [CW-1:0] OUT_CAP = CW'(MAX_OUT_ROW);

  state_t   state_r, state_nxt;
  logic     pen_r, pen_nxt;
  heading_t head_r, head_nxt;
  logic [RW-1:0] pos_row_r, pos_row_nxt;
  logic [RW-1:0] pos_col_r, pos_col_nxt;
  logic [RW-1:0] max_row_r, max_row_nxt;
  logic [RW-1:0] max_col_r, max_col_nxt;
  logic [RW-1:0] k_r, k_nxt;
  logic [RW-1:0] r_lo_r, r_lo_nxt;
  logic [RW-1:0] r_hi_r, r_hi_nxt;
  logic [GRID_SIZE-1:0] mask_r, mask_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]      out_idx_r, out_idx_nxt;
  logic [BITS_W-1:0]     out_bits_r, out_bits_nxt;
  logic [IDX_W-1:0]      out_ext_r, out_ext_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                 accept;
  mode_t                mode;
  logic [DIST_W-1:0]    move_dist;
  logic [RW-1:0]        goal_row, goal_col;
  logic [RW-1:0]        c_lo, c_hi, mv_r_lo, mv_r_hi;
  logic [GRID_SIZE-1:0] mv_mask;

  logic                 shift_en;
  logic                 emit;
  logic                 set_en;
  logic [GRID_SIZE-1:0] rows_q [GRID_SIZE];
  logic [GRID_SIZE-1:0] feedback;
  logic [CW-1:0]        k_ext, mr_ext, mc_ext, last_row_ext;
  logic [GRID_SIZE+BITS_W-1:0] head_wide;

  assign accept    = in_tvalid & in_tready;
  assign mode      = mode_t'(in_tdata[2:0]);
  assign move_dist = in_tdata[7:3];

  // Segment end points, row range and column mask of a move.
  always_comb begin
    logic [CW-1:0] p_ext;
    logic [CW-1:0] d_ext;
    logic [CW-1:0] room;
    logic [CW-1:0] adv_up;
    logic [CW-1:0] adv_dn;
    logic [CW-1:0] c_ext;
    p_ext    = '0;
    d_ext    = CW'(move_dist);
    goal_row = pos_row_r;
    goal_col = pos_col_r;
    if (head_r == HEAD_COL_UP || head_r == HEAD_COL_DOWN) begin
      p_ext = CW'(pos_col_r);
    end else begin
      p_ext = CW'(pos_row_r);
    end
    room   = EDGE_HI - p_ext;
    adv_up = (d_ext > room) ? EDGE_HI : (p_ext + d_ext);
    adv_dn = (d_ext > p_ext) ? '0 : (p_ext - d_ext);
    case (head_r)
      HEAD_COL_UP:   goal_col = RW'(adv_up);
      HEAD_ROW_UP:   goal_row = RW'(adv_up);
      HEAD_COL_DOWN: goal_col = RW'(adv_dn);
      HEAD_ROW_DOWN: goal_row = RW'(adv_dn);
      default:       goal_row = pos_row_r;
    endcase
    mv_r_lo = (goal_row < pos_row_r) ? goal_row : pos_row_r;
    mv_r_hi = (goal_row < pos_row_r) ? pos_row_r : goal_row;
    c_lo    = (goal_col < pos_col_r) ? goal_col : pos_col_r;
    c_hi    = (goal_col < pos_col_r) ? pos_col_r : goal_col;
    for (int c = 0; c < GRID_SIZE; c++) begin
      c_ext      = CW'(c);
      mv_mask[c] = (c_ext >= CW'(c_lo)) && (c_ext <= CW'(c_hi));
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && mode == MODE_MOVE && pen_r) begin
          state_nxt = ST_DRAW;
        end else if (accept && mode == MODE_PRINT) begin
          state_nxt = ST_PRINT;
        end
      end
      ST_DRAW, ST_PRINT: begin
        if (shift_en && k_r == LAST_K) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign k_ext        = CW'(k_r);
  assign mr_ext       = CW'(max_row_r);
  assign mc_ext       = CW'(max_col_r);
  assign last_row_ext = (mr_ext > OUT_CAP) ? OUT_CAP : mr_ext;
  assign head_wide    = (GRID_SIZE + BITS_W)'(rows_q[0]);

  // Outputs of the sequencer.
  always_comb begin
    in_tready = 1'b0;
    shift_en  = 1'b0;
    emit      = 1'b0;
    set_en    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
      end
      ST_DRAW: begin
        shift_en = !out_valid_r || out_tready;
        set_en   = (k_r >= r_lo_r) && (k_r <= r_hi_r);
      end
      ST_PRINT: begin
        shift_en = !out_valid_r || out_tready;
        emit     = shift_en && (k_ext <= last_row_ext);
      end
      default: in_tready = 1'b0;
    endcase
  end

  assign feedback = rows_q[0] | (set_en ? mask_r : '0);

  genvar gi;
  generate
    for (gi = 0; gi < GRID_SIZE; gi++) begin : g_ring
      if (gi == GRID_SIZE - 1) begin : g_tail
        tpp_cell #(.WIDTH(GRID_SIZE)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .d_in     (feedback),
          .q        (rows_q[gi])
        );
      end else begin : g_body
        tpp_cell #(.WIDTH(GRID_SIZE)) u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .d_in     (rows_q[gi+1]),
          .q        (rows_q[gi])
        );
      end
    end
  endgenerate

  // Turtle state and ring step counter.
  always_comb begin
    pen_nxt     = pen_r;
    head_nxt    = head_r;
    pos_row_nxt = pos_row_r;
    pos_col_nxt = pos_col_r;
    max_row_nxt = max_row_r;
    max_col_nxt = max_col_r;
    r_lo_nxt    = r_lo_r;
    r_hi_nxt    = r_hi_r;
    mask_nxt    = mask_r;
    k_nxt       = k_r;
    if (accept) begin
      case (mode)
        MODE_PEN_UP:   pen_nxt  = 1'b0;
        MODE_PEN_DOWN: pen_nxt  = 1'b1;
        MODE_TURN_R:   head_nxt = heading_t'(head_r + 2'd1);
        MODE_TURN_L:   head_nxt = heading_t'(head_r + 2'd3);
        MODE_MOVE: begin
          pos_row_nxt = goal_row;
          pos_col_nxt = goal_col;
          r_lo_nxt    = mv_r_lo;
          r_hi_nxt    = mv_r_hi;
          mask_nxt    = mv_mask;
          if (pen_r) begin
            max_row_nxt = (mv_r_hi > max_row_r) ? mv_r_hi : max_row_r;
            max_col_nxt = (c_hi > max_col_r) ? c_hi : max_col_r;
          end
        end
        default: pen_nxt = pen_r;
      endcase
    end
    if (shift_en) begin
      k_nxt = (k_r == LAST_K) ? '0 : (k_r + RW'(1));
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_bits_nxt  = out_bits_r;
    out_ext_nxt   = out_ext_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = k_ext[IDX_W-1:0];
      out_bits_nxt  = head_wide[BITS_W-1:0];
      out_ext_nxt   = mc_ext[IDX_W-1:0];
      out_last_nxt  = (k_ext == last_row_ext);
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pen_r       <= 1'b0;
      head_r      <= HEAD_COL_UP;
      pos_row_r   <= '0;
      pos_col_r   <= '0;
      max_row_r   <= '0;
      max_col_r   <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pen_r       <= pen_nxt;
      head_r      <= head_nxt;
      pos_row_r   <= pos_row_nxt;
      pos_col_r   <= pos_col_nxt;
      max_row_r   <= max_row_nxt;
      max_col_r   <= max_col_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_lo_r     <= r_lo_nxt;
    r_hi_r     <= r_hi_nxt;
    mask_r     <= mask_nxt;
    out_idx_r  <= out_idx_nxt;
    out_bits_r <= out_bits_nxt;
    out_ext_r  <= out_ext_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_ext_r, out_bits_r, out_idx_r};
  assign out_tlast  = out_last_r;

endmodule
